// ----- rtl/mcsa_pkg.sv -----
// Shared constants, types and helpers of the MIPS constant store address scan.
package mcsa_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned NumRegs    = 32;
  localparam int unsigned RegAddrW   = 5;
  localparam int unsigned MatchW     = 24;
  localparam int unsigned IndexBitsDefault = 24;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  localparam logic [5:0] OpLui   = 6'h0F;
  localparam logic [5:0] OpAddiu = 6'h09;
  localparam logic [5:0] OpOri   = 6'h0D;
  localparam logic [5:0] OpSd    = 6'h3F;

  localparam logic [ApbAddrW-1:0] AddrTarget = 3'h0;

  typedef struct packed {
    logic                en;
    logic [RegAddrW-1:0] addr;
    logic [WordW-1:0]    data;
  } wr_t;

  function automatic logic [WordW-1:0] sext16(input logic [15:0] imm);
    logic [WordW-1:0] r;
    r = {16'h0000, imm};
    if (imm[15]) begin
      r = r | 32'hFFFF_0000;
    end
    return r;
  endfunction

endpackage

// ----- rtl/mips_constant_store_address_scan.sv -----
// Top level of the MIPS constant store address scan.
// A request is read from the register RAM at acceptance and executes from stage 1 once the output can take a result.
// A match result is registered into the output register when its request executes from stage 1.
// Throughput: one request per cycle while the match output is not held by back-pressure.
// Reset clears the valid bits of the register table, the word counter and the target.
// A request marked as scan start clears the valid bits and counter before it executes.
module mips_constant_store_address_scan #(
  parameter int unsigned INDEX_BITS = mcsa_pkg::IndexBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [31:0]                       instr_word_i,
  input  logic                              scan_start_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mcsa_pkg::MatchW-1:0]       match_index_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mcsa_pkg::ApbAddrW-1:0]     paddr,
  input  logic [mcsa_pkg::ApbDataW-1:0]     pwdata,
  output logic [mcsa_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);

  localparam int unsigned ExtW = (INDEX_BITS > mcsa_pkg::MatchW) ? INDEX_BITS
                                                                 : mcsa_pkg::MatchW;

  logic [mcsa_pkg::WordW-1:0]    target;
  logic                          in_fire;
  logic                          s1_fire;
  logic                          s1_valid_q, s1_valid_d;
  logic [31:0]                   s1_word_q;
  logic                          s1_start_q;
  logic [mcsa_pkg::NumRegs-1:0]  vld_q, vld_d;
  logic [INDEX_BITS-1:0]         cnt_q, cnt_d;
  logic [INDEX_BITS-1:0]         idx;
  logic [ExtW-1:0]               idx_ext;
  mcsa_pkg::wr_t                 fwd_q, fwd_d;
  mcsa_pkg::wr_t                 wr;
  logic [mcsa_pkg::WordW-1:0]    ram_rdata;
  logic [mcsa_pkg::WordW-1:0]    rs_val;
  logic [mcsa_pkg::WordW-1:0]    ea;
  logic [5:0]                    op;
  logic [mcsa_pkg::RegAddrW-1:0] rs;
  logic [mcsa_pkg::RegAddrW-1:0] rt;
  logic [15:0]                   imm;
  logic                          hit;
  logic                          out_valid_q, out_valid_d;
  logic [mcsa_pkg::MatchW-1:0]   out_idx_q, out_idx_d;

  mcsa_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .target_o (target)
  );

  mcsa_ram #(
    .Width (mcsa_pkg::WordW),
    .Depth (mcsa_pkg::NumRegs)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (in_fire),
    .raddr_i (instr_word_i[25:21]),
    .rdata_o (ram_rdata)
  );

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  assign op  = s1_word_q[31:26];
  assign rs  = s1_word_q[25:21];
  assign rt  = s1_word_q[20:16];
  assign imm = s1_word_q[15:0];

  always_comb begin
    if (s1_start_q) begin
      rs_val = '0;
    end else if (fwd_q.en && (fwd_q.addr == rs)) begin
      rs_val = fwd_q.data;
    end else if (vld_q[rs]) begin
      rs_val = ram_rdata;
    end else begin
      rs_val = '0;
    end
  end

  assign ea      = rs_val + mcsa_pkg::sext16(imm);
  assign idx     = s1_start_q ? '0 : cnt_q;
  assign idx_ext = ExtW'(idx);

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = rt;
    wr.data = ea;
    hit     = 1'b0;
    case (op)
      mcsa_pkg::OpLui: begin
        wr.en   = 1'b1;
        wr.data = {imm, 16'h0000};
      end
      mcsa_pkg::OpAddiu: begin
        wr.en   = 1'b1;
        wr.data = ea;
      end
      mcsa_pkg::OpOri: begin
        wr.en   = 1'b1;
        wr.data = rs_val | {16'h0000, imm};
      end
      mcsa_pkg::OpSd: begin
        hit = (ea == target);
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
    wr.en = wr.en && s1_fire && (rt != '0);
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    vld_d       = vld_q;
    cnt_d       = cnt_q;
    fwd_d       = fwd_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_fire) begin
      s1_valid_d = 1'b0;
      if (s1_start_q) begin
        vld_d = '0;
      end
      if (wr.en) begin
        vld_d[wr.addr] = 1'b1;
      end
      cnt_d = idx + INDEX_BITS'(1);
      fwd_d = wr;
      if (hit) begin
        out_valid_d = 1'b1;
        out_idx_d   = idx_ext[mcsa_pkg::MatchW-1:0];
      end
    end
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      vld_q       <= '0;
      cnt_q       <= '0;
      fwd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      vld_q       <= vld_d;
      cnt_q       <= cnt_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q  <= instr_word_i;
      s1_start_q <= scan_start_i;
    end
    out_idx_q <= out_idx_d;
  end

  assign out_valid_o   = out_valid_q;
  assign match_index_o = out_idx_q;

endmodule

// ----- rtl/mcsa_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module mcsa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/mcsa_cfg.sv -----
// APB-style configuration register block holding the target store address.
module mcsa_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mcsa_pkg::ApbAddrW-1:0]       paddr,
  input  logic [mcsa_pkg::ApbDataW-1:0]       pwdata,
  output logic [mcsa_pkg::ApbDataW-1:0]       prdata,
  output logic                                pready,
  output logic [mcsa_pkg::WordW-1:0]          target_o
);

  logic [mcsa_pkg::WordW-1:0] target_q;
  logic [mcsa_pkg::WordW-1:0] target_d;

  always_comb begin
    target_d = target_q;
    if (psel && penable && pwrite && (paddr == mcsa_pkg::AddrTarget)) begin
      target_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else begin
      target_q <= target_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == mcsa_pkg::AddrTarget) begin
      prdata = target_q;
    end
  end

  assign pready   = 1'b1;
  assign target_o = target_q;

endmodule
